@@ rtl/kvt_pkg.sv @@
// Shared types and codes for the key/value table unit.
// No dependencies; used by kvt_cell, kvt_ctrl, key_value_table_unit and the testbench.
package kvt_pkg;

    localparam int WORD_BITS = 64;
    localparam int KIND_BITS = 2;
    localparam int STATUS_BITS = 2;

    typedef enum logic [KIND_BITS-1:0] {
        KIND_PUT = 2'd0,
        KIND_GET = 2'd1,
        KIND_DEL = 2'd2
    } t_kind;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    // Search token handed from cell to cell
    typedef struct packed {
        logic active;   // token sits at this point of the chain
        logic hit;      // a valid entry upstream matched the key
        logic free;     // a free entry was seen upstream
    } t_token;

endpackage

@@ rtl/kvt_cell.sv @@
// One table entry of the key/value chain: valid mark, key, value and search token stage.
// Depends on kvt_pkg.
module kvt_cell #(
    parameter int KEY_BITS   = 64,
    parameter int VALUE_BITS = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  kvt_pkg::t_kind        i_kind,
    input  logic [KEY_BITS-1:0]   i_key,
    input  logic [VALUE_BITS-1:0] i_value,
    input  logic                  i_fill,
    input  kvt_pkg::t_token       i_tok,
    input  logic [VALUE_BITS-1:0] i_rd,
    output kvt_pkg::t_token       o_tok,
    output logic [VALUE_BITS-1:0] o_rd
);

    logic                  r_valid, n_valid;
    logic                  r_cand, n_cand;
    logic [KEY_BITS-1:0]   r_key, n_key;
    logic [VALUE_BITS-1:0] r_value, n_value;
    kvt_pkg::t_token       r_tok, n_tok;
    logic [VALUE_BITS-1:0] r_rd, n_rd;
    logic                  hit_here;

    // first valid match along the chain takes the request
    assign hit_here = i_tok.active && !i_tok.hit && r_valid && (r_key == i_key);

    always_comb begin
        n_valid = r_valid;
        n_cand  = r_cand;
        n_key   = r_key;
        n_value = r_value;
        n_tok   = i_tok;
        n_rd    = i_rd;
        if (hit_here) begin
            n_tok.hit = 1'b1;
            case (i_kind)
                kvt_pkg::KIND_PUT: n_value = i_value;
                kvt_pkg::KIND_GET: n_rd = r_value;
                kvt_pkg::KIND_DEL: n_valid = 1'b0;
                default: ;
            endcase
        end
        if (i_tok.active) begin
            // mark ourselves as the lowest free entry if nobody upstream was free
            n_cand     = !r_valid && !i_tok.free;
            n_tok.free = i_tok.free || !r_valid;
        end
        if (i_fill && r_cand) begin
            n_valid = 1'b1;
            n_key   = i_key;
            n_value = i_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_cand  <= 1'b0;
            r_tok   <= '0;
        end else begin
            r_valid <= n_valid;
            r_cand  <= n_cand;
            r_tok   <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key   <= n_key;
        r_value <= n_value;
        r_rd    <= n_rd;
    end

    assign o_tok = r_tok;
    assign o_rd  = r_rd;

endmodule

@@ rtl/kvt_ctrl.sv @@
// Request/result control for the key/value chain: holds the transaction, launches
// the search token, builds the result and issues the fill. Depends on kvt_pkg.
module kvt_ctrl #(
    parameter int KEY_BITS   = 64,
    parameter int VALUE_BITS = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [kvt_pkg::KIND_BITS-1:0]   i_kind,
    input  logic [kvt_pkg::WORD_BITS-1:0]   i_key,
    input  logic [kvt_pkg::WORD_BITS-1:0]   i_value,
    output logic                            o_busy,
    output logic                            o_done,
    output logic [kvt_pkg::STATUS_BITS-1:0] o_status,
    output logic [kvt_pkg::WORD_BITS-1:0]   o_read_value,
    output kvt_pkg::t_kind                  o_req_kind,
    output logic [KEY_BITS-1:0]             o_req_key,
    output logic [VALUE_BITS-1:0]           o_req_value,
    output kvt_pkg::t_token                 o_launch,
    output logic                            o_fill,
    input  kvt_pkg::t_token                 i_tok_last,
    input  logic [VALUE_BITS-1:0]           i_rd_last
);

    logic                          r_busy, n_busy;
    logic                          r_launch;
    logic                          r_done;
    kvt_pkg::t_kind                r_kind;
    logic [KEY_BITS-1:0]           r_key;
    logic [VALUE_BITS-1:0]         r_value;
    kvt_pkg::t_status              r_status, n_status;
    logic [kvt_pkg::WORD_BITS-1:0] r_read_value, n_read_value;
    logic                          accept;

    assign accept = i_start && !r_busy;

    always_comb begin
        n_busy = r_busy;
        if (accept) begin
            n_busy = 1'b1;
        end else if (i_tok_last.active) begin
            n_busy = 1'b0;
        end
    end

    // result from the token leaving the last cell
    always_comb begin
        n_status     = kvt_pkg::ST_NOT_FOUND;
        n_read_value = '0;
        case (r_kind)
            kvt_pkg::KIND_PUT: begin
                if (i_tok_last.hit || i_tok_last.free) begin
                    n_status = kvt_pkg::ST_OK;
                end else begin
                    n_status = kvt_pkg::ST_FULL;
                end
            end
            kvt_pkg::KIND_GET: begin
                if (i_tok_last.hit) begin
                    n_status     = kvt_pkg::ST_OK;
                    n_read_value = kvt_pkg::WORD_BITS'(i_rd_last);
                end
            end
            kvt_pkg::KIND_DEL: begin
                if (i_tok_last.hit) begin
                    n_status = kvt_pkg::ST_OK;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_launch <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_busy   <= n_busy;
            r_launch <= accept;
            r_done   <= i_tok_last.active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind  <= kvt_pkg::t_kind'(i_kind);
            r_key   <= i_key[KEY_BITS-1:0];
            r_value <= i_value[VALUE_BITS-1:0];
        end
        if (i_tok_last.active) begin
            r_status     <= n_status;
            r_read_value <= n_read_value;
        end
    end

    assign o_launch     = '{active: r_launch, hit: 1'b0, free: 1'b0};
    assign o_fill       = i_tok_last.active && (r_kind == kvt_pkg::KIND_PUT)
                          && !i_tok_last.hit && i_tok_last.free;
    assign o_req_kind   = r_kind;
    assign o_req_key    = r_key;
    assign o_req_value  = r_value;
    assign o_busy       = r_busy;
    assign o_done       = r_done;
    assign o_status     = r_status;
    assign o_read_value = r_read_value;

endmodule

@@ rtl/key_value_table_unit.sv @@
// Top level of the fully associative key/value table: controller plus a chain of
// ENTRIES cells. Depends on kvt_pkg, kvt_cell and kvt_ctrl.
//
// Usage:
//   Request channel: a transaction (i_kind, i_key, i_value) is taken at a rising
//   edge with start high and busy low. i_kind: put, get or delete. Only the low
//   KEY_BITS of i_key and VALUE_BITS of i_value are used.
//   Result channel: o_done is high for exactly one cycle with o_status (ok, not
//   found, full) and o_read_value (value of a successful get, else zero). The
//   receiver cannot stall; the result is gone after that cycle.
//   Search: after the accepting edge a search token walks the cell chain, one
//   cell per clock. o_done is registered from the token leaving the last
//   cell, and busy falls at the edge where o_done rises, so the next
//   transaction can be taken at the edge that ends the o_done cycle; none is
//   taken before the result of the last. The chain length sets the search time.
//   A put that misses marks the lowest free cell on the way and writes it when
//   the token leaves the last cell.
//   Reset (synchronous, active low) clears all valid marks, the token chain and
//   busy; stored keys and values are not cleared and need no clearing pass.
module key_value_table_unit #(
    parameter int ENTRIES    = 64,
    parameter int KEY_BITS   = 64,
    parameter int VALUE_BITS = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [kvt_pkg::KIND_BITS-1:0]   i_kind,
    input  logic [kvt_pkg::WORD_BITS-1:0]   i_key,
    input  logic [kvt_pkg::WORD_BITS-1:0]   i_value,
    output logic                            o_done,
    output logic [kvt_pkg::STATUS_BITS-1:0] o_status,
    output logic [kvt_pkg::WORD_BITS-1:0]   o_read_value
);

    // request broadcast to every cell
    kvt_pkg::t_kind        req_kind;
    logic [KEY_BITS-1:0]   req_key;
    logic [VALUE_BITS-1:0] req_value;
    logic                  fill;

    // token and read data between neighbors; index 0 is the controller's launch
    kvt_pkg::t_token       tok [0:ENTRIES];
    logic [VALUE_BITS-1:0] rd  [0:ENTRIES];

    assign rd[0] = '0;

    kvt_ctrl #(
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_kind       (i_kind),
        .i_key        (i_key),
        .i_value      (i_value),
        .o_busy       (busy),
        .o_done       (o_done),
        .o_status     (o_status),
        .o_read_value (o_read_value),
        .o_req_kind   (req_kind),
        .o_req_key    (req_key),
        .o_req_value  (req_value),
        .o_launch     (tok[0]),
        .o_fill       (fill),
        .i_tok_last   (tok[ENTRIES]),
        .i_rd_last    (rd[ENTRIES])
    );

    // cell i holds entry i; lower index is nearer the launch point, so the
    // lowest-numbered match and free entry are the first ones the token meets
    for (genvar gi = 0; gi < ENTRIES; gi++) begin : g_cell
        kvt_cell #(
            .KEY_BITS   (KEY_BITS),
            .VALUE_BITS (VALUE_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_kind  (req_kind),
            .i_key   (req_key),
            .i_value (req_value),
            .i_fill  (fill),
            .i_tok   (tok[gi]),
            .i_rd    (rd[gi]),
            .o_tok   (tok[gi+1]),
            .o_rd    (rd[gi+1])
        );
    end

endmodule

@@ dv/tb_key_value_table_unit.sv @@
// Self-checking testbench for key_value_table_unit: directed and random put/get/delete
// transactions checked against a shadow copy of the table. Depends on kvt_pkg and the RTL.
module tb_key_value_table_unit;

    localparam int ENTRIES    = 64;
    localparam int KEY_BITS   = 64;
    localparam int VALUE_BITS = 64;

    localparam int CLK_PERIOD   = 20;
    localparam int RESET_CYCLES = 11;
    // The limit sits far above the slowest legal run, to give it plenty of margin.
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_ITEMS = 1750;
    localparam int KEY_POOL     = 24;
    localparam int MAX_REPORTS  = 10;

    // Kind code the block does not define: must change nothing and answer not found.
    localparam logic [kvt_pkg::KIND_BITS-1:0] KIND_UNKNOWN = 2'd3;

    localparam logic [kvt_pkg::WORD_BITS-1:0] ALL_ONES   = '1;
    localparam logic [kvt_pkg::WORD_BITS-1:0] KEY_MASK   =
        (KEY_BITS >= kvt_pkg::WORD_BITS) ? ALL_ONES : ((64'd1 << KEY_BITS) - 64'd1);
    localparam logic [kvt_pkg::WORD_BITS-1:0] VALUE_MASK =
        (VALUE_BITS >= kvt_pkg::WORD_BITS) ? ALL_ONES : ((64'd1 << VALUE_BITS) - 64'd1);

    typedef struct {
        logic [kvt_pkg::STATUS_BITS-1:0] status;
        logic [kvt_pkg::WORD_BITS-1:0]   read_value;
    } t_reply;

    // Random phases: fill pushes the table to full, drain empties it, mixed does both.
    typedef enum {MODE_FILL, MODE_DRAIN, MODE_MIXED} t_mode;

    // Shadow table plus the queue of replies still owed by the block.
    class table_scoreboard;
        logic                          valid_mark [ENTRIES];
        logic [kvt_pkg::WORD_BITS-1:0] stored_key [ENTRIES];
        logic [kvt_pkg::WORD_BITS-1:0] stored_val [ENTRIES];
        t_reply                        replies_due[$];
        int                            failures;
        int                            replies_seen;
        int                            kind_seen  [4];
        int                            status_seen[3];
        int                            peak_live;

        function new();
            foreach (valid_mark[i]) valid_mark[i] = 1'b0;
            failures     = 0;
            replies_seen = 0;
            peak_live    = 0;
            foreach (kind_seen[i]) kind_seen[i] = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        function int live_count();
            int n;
            n = 0;
            foreach (valid_mark[i]) if (valid_mark[i]) n++;
            return n;
        endfunction

        // Key of the n-th valid entry, counting from entry 0.
        function logic [kvt_pkg::WORD_BITS-1:0] live_key(int n);
            foreach (valid_mark[i]) begin
                if (valid_mark[i]) begin
                    if (n == 0) return stored_key[i];
                    n--;
                end
            end
            return '0;
        endfunction

        function int outstanding();
            return replies_due.size();
        endfunction

        // Apply one accepted transaction to the shadow table and queue its reply.
        function void predict_request(logic [kvt_pkg::KIND_BITS-1:0] kind,
                                      logic [kvt_pkg::WORD_BITS-1:0] key,
                                      logic [kvt_pkg::WORD_BITS-1:0] value);
            t_reply                        r;
            logic [kvt_pkg::WORD_BITS-1:0] k;
            logic [kvt_pkg::WORD_BITS-1:0] v;
            int                            hit;
            int                            slot;
            int                            live;
            k   = key & KEY_MASK;
            v   = value & VALUE_MASK;
            hit = -1;
            // Lowest-numbered valid match wins
            for (int i = ENTRIES - 1; i >= 0; i--)
                if (valid_mark[i] && stored_key[i] == k) hit = i;
            r.status     = kvt_pkg::ST_NOT_FOUND;
            r.read_value = '0;
            case (kind)
                kvt_pkg::KIND_PUT: begin
                    if (hit >= 0) begin
                        stored_val[hit] = v;
                        r.status = kvt_pkg::ST_OK;
                    end else begin
                        slot = -1;
                        for (int i = ENTRIES - 1; i >= 0; i--)
                            if (!valid_mark[i]) slot = i;
                        if (slot < 0) begin
                            r.status = kvt_pkg::ST_FULL;
                        end else begin
                            valid_mark[slot] = 1'b1;
                            stored_key[slot] = k;
                            stored_val[slot] = v;
                            r.status = kvt_pkg::ST_OK;
                        end
                    end
                end
                kvt_pkg::KIND_GET: begin
                    if (hit >= 0) begin
                        r.read_value = stored_val[hit];
                        r.status = kvt_pkg::ST_OK;
                    end
                end
                kvt_pkg::KIND_DEL: begin
                    if (hit >= 0) begin
                        valid_mark[hit] = 1'b0;
                        r.status = kvt_pkg::ST_OK;
                    end
                end
                default: ;
            endcase
            kind_seen[kind]++;
            status_seen[r.status]++;
            live = live_count();
            if (live > peak_live) peak_live = live;
            replies_due.push_back(r);
        endfunction

        function void flag(string what, logic [kvt_pkg::WORD_BITS-1:0] want,
                           logic [kvt_pkg::WORD_BITS-1:0] got);
            failures++;
            if (failures <= MAX_REPORTS)
                $display("MISMATCH reply %0d %s: expected %h, got %h",
                         replies_seen, what, want, got);
        endfunction

        function void check_reply(logic [kvt_pkg::STATUS_BITS-1:0] status,
                                  logic [kvt_pkg::WORD_BITS-1:0] read_value);
            t_reply want;
            replies_seen++;
            if (replies_due.size() == 0) begin
                flag("with no transaction outstanding, status", '0, status);
                return;
            end
            want = replies_due.pop_front();
            if (status !== want.status) flag("status", want.status, status);
            if (read_value !== want.read_value) flag("read_value", want.read_value, read_value);
        endfunction
    endclass

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            start;
    logic                            busy;
    logic [kvt_pkg::KIND_BITS-1:0]   i_kind;
    logic [kvt_pkg::WORD_BITS-1:0]   i_key;
    logic [kvt_pkg::WORD_BITS-1:0]   i_value;
    logic                            o_done;
    logic [kvt_pkg::STATUS_BITS-1:0] o_status;
    logic [kvt_pkg::WORD_BITS-1:0]   o_read_value;

    table_scoreboard               book = new();
    logic [kvt_pkg::WORD_BITS-1:0] key_pool[KEY_POOL];
    int                            random_sent;

    key_value_table_unit #(
        .ENTRIES    (ENTRIES),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_kind       (i_kind),
        .i_key        (i_key),
        .i_value      (i_value),
        .o_done       (o_done),
        .o_status     (o_status),
        .o_read_value (o_read_value)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Result side: o_done lasts one cycle and cannot be stalled, so every strobe
    // sampled at a rising edge is a reply transaction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) book.check_reply(o_status, o_read_value);
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin
        #(CYCLE_LIMIT * CLK_PERIOD);
        $display("Test completed with failures");
        $finish;
    end

    function automatic logic [kvt_pkg::WORD_BITS-1:0] rand_word();
        return {$urandom(), $urandom()};
    endfunction

    // Mostly keys that hit: live entries, then a recurring pool, extremes, random words.
    function automatic logic [kvt_pkg::WORD_BITS-1:0] pick_key();
        int r;
        int live;
        r    = $urandom_range(0, 99);
        live = book.live_count();
        if (live > 0 && r < 50) return book.live_key($urandom_range(0, live - 1));
        if (r < 75) return key_pool[$urandom_range(0, KEY_POOL - 1)];
        if (r < 80) return ($urandom_range(0, 1) != 0) ? ALL_ONES : '0;
        return rand_word();
    endfunction

    function automatic logic [kvt_pkg::WORD_BITS-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return '0;
        if (r < 16) return ALL_ONES;
        return rand_word();
    endfunction

    // Called right after a rising edge. Holds start high until the edge that takes
    // the transaction and returns at that edge with start still high, so a
    // back-to-back follower needs no toggle.
    task automatic send_request(input logic [kvt_pkg::KIND_BITS-1:0] kind,
                                input logic [kvt_pkg::WORD_BITS-1:0] key,
                                input logic [kvt_pkg::WORD_BITS-1:0] value);
        start   <= 1'b1;
        i_kind  <= kind;
        i_key   <= key;
        i_value <= value;
        do @(posedge i_clk); while (busy);
        book.predict_request(kind, key, value);
    endtask

    task automatic idle_cycles(input int n);
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Sender holds off until every reply has come back.
    task automatic wait_drained();
        if (book.outstanding() != 0) begin
            start <= 1'b0;
            while (book.outstanding() != 0) @(posedge i_clk);
        end
    endtask

    task automatic random_item(input t_mode mode);
        int r;
        r = $urandom_range(0, 99);
        case (mode)
            MODE_FILL: begin
                if (r < 80) send_request(kvt_pkg::KIND_PUT, rand_word(), pick_value());
                else if (r < 88) send_request(kvt_pkg::KIND_PUT, pick_key(), pick_value());
                else if (r < 96) send_request(kvt_pkg::KIND_GET, pick_key(), pick_value());
                else send_request(kvt_pkg::KIND_DEL, pick_key(), pick_value());
            end
            MODE_DRAIN: begin
                if (r < 70) send_request(kvt_pkg::KIND_DEL, pick_key(), pick_value());
                else if (r < 88) send_request(kvt_pkg::KIND_GET, pick_key(), pick_value());
                else if (r < 97) send_request(kvt_pkg::KIND_PUT, pick_key(), pick_value());
                else send_request(KIND_UNKNOWN, pick_key(), pick_value());
            end
            default: begin
                if (r < 35) send_request(kvt_pkg::KIND_PUT, pick_key(), pick_value());
                else if (r < 65) send_request(kvt_pkg::KIND_GET, pick_key(), pick_value());
                else if (r < 92) send_request(kvt_pkg::KIND_DEL, pick_key(), pick_value());
                else send_request(KIND_UNKNOWN, pick_key(), pick_value());
            end
        endcase
    endtask

    initial begin
        t_mode mode;
        int    phase_len;
        int    burst_len;
        int    r;

        start   <= 1'b0;
        i_kind  <= kvt_pkg::KIND_PUT;
        i_key   <= '0;
        i_value <= '0;
        i_rst_n <= 1'b0;
        foreach (key_pool[i]) key_pool[i] = rand_word();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty table, extreme keys and values, overwrite, unknown kind,
        // delete then re-fill of the lowest free entry.
        send_request(kvt_pkg::KIND_GET, '0,       ALL_ONES);
        send_request(kvt_pkg::KIND_DEL, ALL_ONES, '0);
        send_request(KIND_UNKNOWN,      '0,       ALL_ONES);
        send_request(kvt_pkg::KIND_PUT, '0,       ALL_ONES);
        send_request(kvt_pkg::KIND_PUT, ALL_ONES, '0);
        send_request(kvt_pkg::KIND_GET, '0,       '0);
        send_request(kvt_pkg::KIND_GET, ALL_ONES, ALL_ONES);
        send_request(kvt_pkg::KIND_PUT, '0,       64'h5555_5555_5555_5555);
        send_request(kvt_pkg::KIND_GET, '0,       '0);
        send_request(KIND_UNKNOWN,      '0,       '0);
        send_request(kvt_pkg::KIND_GET, '0,       '0);
        idle_cycles(3);
        send_request(kvt_pkg::KIND_DEL, '0,       ALL_ONES);
        send_request(kvt_pkg::KIND_GET, '0,       '0);
        send_request(kvt_pkg::KIND_DEL, '0,       '0);
        send_request(kvt_pkg::KIND_PUT, 64'hAAAA_AAAA_AAAA_AAAA, 64'hAAAA_AAAA_AAAA_AAAA);
        send_request(kvt_pkg::KIND_PUT, 64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001);
        send_request(kvt_pkg::KIND_GET, 64'h8000_0000_0000_0000, '0);
        send_request(kvt_pkg::KIND_GET, 64'hAAAA_AAAA_AAAA_AAAA, '0);
        send_request(kvt_pkg::KIND_DEL, ALL_ONES, '0);
        send_request(kvt_pkg::KIND_GET, ALL_ONES, '0);
        wait_drained();

        // Random: phases of one flavor, sent in bursts. The first phase fills the
        // table so the full case shows up early; later ones pick a flavor at random.
        random_sent = 0;
        mode        = MODE_FILL;
        while (random_sent < RANDOM_ITEMS) begin
            phase_len = (mode == MODE_FILL) ? $urandom_range(80, 160) : $urandom_range(40, 140);
            while (phase_len > 0 && random_sent < RANDOM_ITEMS) begin
                burst_len = $urandom_range(1, 12);
                while (burst_len > 0 && phase_len > 0 && random_sent < RANDOM_ITEMS) begin
                    random_item(mode);
                    burst_len--;
                    phase_len--;
                    random_sent++;
                end
                // Gaps of varying length land start on every cycle of the busy window
                if ($urandom_range(0, 99) >= 30) idle_cycles($urandom_range(1, ENTRIES + 16));
            end
            if ($urandom_range(0, 2) == 0) wait_drained();
            r = $urandom_range(0, 99);
            mode = (r < 35) ? MODE_FILL : (r < 65) ? MODE_DRAIN : MODE_MIXED;
        end

        // Drain, then give the block one more search time to show any stray reply.
        wait_drained();
        repeat (ENTRIES + 4) @(posedge i_clk);
        if (book.outstanding() != 0) begin
            $display("MISSING %0d replies never arrived", book.outstanding());
            book.failures += book.outstanding();
        end

        $display("Run covered %0d put, %0d get, %0d delete, %0d unknown-kind transactions.",
                 book.kind_seen[kvt_pkg::KIND_PUT], book.kind_seen[kvt_pkg::KIND_GET],
                 book.kind_seen[kvt_pkg::KIND_DEL], book.kind_seen[KIND_UNKNOWN]);
        $display("Replies: %0d ok, %0d not found, %0d table full; peak occupancy %0d of %0d.",
                 book.status_seen[kvt_pkg::ST_OK], book.status_seen[kvt_pkg::ST_NOT_FOUND],
                 book.status_seen[kvt_pkg::ST_FULL], book.peak_live, ENTRIES);
        if (book.failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

@@ key_value_table_unit.f @@
rtl/kvt_pkg.sv
rtl/kvt_cell.sv
rtl/kvt_ctrl.sv
rtl/key_value_table_unit.sv
dv/tb_key_value_table_unit.sv
